FILE: sv/fas_pkg.sv
`default_nettype none
package fas_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned SigW  = FracW + 1;
    localparam int unsigned SumW  = SigW + 1;
    localparam int unsigned LzW   = 5;

    typedef enum logic [1:0] {
        ST_NORMAL    = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // align stage output
    typedef struct packed {
        logic                  bypass;
        logic [WordW-1:0]      bypass_word;
        logic                  sign;
        logic [ExpW-1:0]       exp;
        logic                  sub;
        logic [SigW-1:0]       mb;
        logic [SigW-1:0]       ms;
        logic                  borrow;
    } t_align;

    // add stage output
    typedef struct packed {
        logic                  bypass;
        logic [WordW-1:0]      bypass_word;
        logic                  sign;
        logic [ExpW-1:0]       exp;
        logic [SumW-1:0]       sum;
        logic [LzW-1:0]        lz;
    } t_sum;

    typedef struct packed {
        logic [WordW-1:0] word;
        t_status          status;
    } t_result;
endpackage
`default_nettype wire

FILE: sv/fas_align.sv
`default_nettype none
module fas_align (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic                     i_sub,
    input  wire logic [fas_pkg::WordW-1:0] i_a,
    input  wire logic [fas_pkg::WordW-1:0] i_b,
    output logic                          o_valid,
    output fas_pkg::t_align               o_data
);
    logic [fas_pkg::WordW-1:0] b, big, sml;
    logic [fas_pkg::ExpW-1:0]  ea, eb, es, diff;
    logic [fas_pkg::SigW-1:0]  ms;
    logic [2*fas_pkg::SigW-1:0] ext, shifted;
    fas_pkg::t_align n_data, r_data;
    logic r_valid;

    always_comb begin
        b = i_b ^ {i_sub, {(fas_pkg::WordW-1){1'b0}}};
        ea = i_a[30:23];
        eb = b[30:23];
        if (i_a[30:0] >= b[30:0]) begin
            big = i_a; sml = b;
        end else begin
            big = b; sml = i_a;
        end
        es = sml[30:23];
        diff = big[30:23] - es;
        ms = {1'b1, sml[22:0]};
        ext = {ms, {fas_pkg::SigW{1'b0}}};
        shifted = (diff <= 8'd24) ? (ext >> diff) : '0;
        n_data.bypass = (ea == '0) || (eb == '0);
        n_data.bypass_word = (ea != '0) ? i_a : ((eb != '0) ? b : '0);
        n_data.sign = big[31];
        n_data.exp = big[30:23];
        n_data.sub = big[31] ^ sml[31];
        n_data.mb = {1'b1, big[22:0]};
        n_data.ms = shifted[2*fas_pkg::SigW-1:fas_pkg::SigW];
        n_data.borrow = shifted[fas_pkg::SigW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

FILE: sv/fas_add.sv
`default_nettype none
module fas_add (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  fas_pkg::t_align      i_data,
    output logic                 o_valid,
    output fas_pkg::t_sum        o_data
);
    logic [fas_pkg::SumW-1:0] sum;
    logic [fas_pkg::LzW-1:0]  lz;
    fas_pkg::t_sum n_data, r_data;
    logic r_valid;

    always_comb begin
        if (i_data.sub) begin
            sum = {1'b0, i_data.mb} - {1'b0, i_data.ms}
                - {{(fas_pkg::SumW-1){1'b0}}, i_data.borrow};
        end else begin
            sum = {1'b0, i_data.mb} + {1'b0, i_data.ms};
        end
        lz = '0;
        for (int i = 0; i < fas_pkg::SigW; i++) begin
            if (sum[i]) begin
                lz = fas_pkg::LzW'(fas_pkg::SigW - 1 - i);
            end
        end
        n_data.bypass = i_data.bypass;
        n_data.bypass_word = i_data.bypass_word;
        n_data.sign = i_data.sign;
        n_data.exp = i_data.exp;
        n_data.sum = sum;
        n_data.lz = lz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

FILE: sv/fas_norm.sv
`default_nettype none
module fas_norm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  fas_pkg::t_sum        i_data,
    output logic                 o_valid,
    output fas_pkg::t_result     o_data
);
    logic signed [9:0] exp;
    logic [fas_pkg::SumW-1:0] sig;
    fas_pkg::t_result n_data, r_data;
    logic r_valid;

    always_comb begin
        if (i_data.sum[fas_pkg::SumW-1]) begin
            sig = i_data.sum >> 1;
            exp = $signed({2'b00, i_data.exp}) + 10'sd1;
        end else begin
            sig = i_data.sum << i_data.lz;
            exp = $signed({2'b00, i_data.exp}) - $signed({5'b0, i_data.lz});
        end
        n_data.status = fas_pkg::ST_NORMAL;
        if (i_data.bypass) begin
            n_data.word = i_data.bypass_word;
        end else if (i_data.sum == '0) begin
            n_data.word = '0;
        end else if (exp >= 10'sd255) begin
            n_data.word = {i_data.sign, 8'hFF, 23'd0};
            n_data.status = fas_pkg::ST_OVERFLOW;
        end else if (exp <= 10'sd0) begin
            n_data.word = {i_data.sign, 31'd0};
            n_data.status = fas_pkg::ST_UNDERFLOW;
        end else begin
            n_data.word = {i_data.sign, exp[7:0], sig[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

FILE: sv/float32_add_sub_truncating_top.sv
`default_nettype none
// channel | dir | tdata                           | tuser
// s_axis  | in  | [31:0] operand_a, [63:32] operand_b | [0] req_type
// m_axis  | out | [31:0] result_word, [33:32] status (40 bits) | -
// Three register stages (align, add + leading-zero count, normalize).
// One transaction per cycle while the pipeline is not stalled.
// Stall: whole pipeline holds when the output stage is full and not taken.
// Reset: i_rst_n synchronous, clears valid bits only.
module float32_add_sub_truncating_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // operand_a, operand_b
    input  wire logic        s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // result_word, status
);
    logic en, v1, v2, v3;
    fas_pkg::t_align d1;
    fas_pkg::t_sum d2;
    fas_pkg::t_result d3;

    assign en = m_axis_tready || !v3;
    assign s_axis_tready = en;

    fas_align u_align (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid), .i_sub(s_axis_tuser),
        .i_a(s_axis_tdata[31:0]), .i_b(s_axis_tdata[63:32]),
        .o_valid(v1), .o_data(d1));
    fas_add u_add (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v1), .i_data(d1), .o_valid(v2), .o_data(d2));
    fas_norm u_norm (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v2), .i_data(d2), .o_valid(v3), .o_data(d3));

    assign m_axis_tvalid = v3;
    assign m_axis_tdata = {6'd0, d3.status, d3.word};

    a_ovf_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && d3.status == fas_pkg::ST_OVERFLOW |-> d3.word[30:0] == 31'h7F800000)
        else $error("overflow not infinity");
    a_unf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && d3.status == fas_pkg::ST_UNDERFLOW |-> d3.word[30:0] == '0)
        else $error("underflow not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(v1) && $stable(v2))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

FILE: sim/float32_add_sub_truncating_checker.sv
`timescale 1ns / 1ps
module float32_add_sub_truncating_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    output int               o_fail_count,
    output int               o_pending
);
    fas_pkg::t_result sums_due[$];

    function automatic fas_pkg::t_result fadd_trunc(input logic sub_op,
                                                    input logic [31:0] a,
                                                    input logic [31:0] b_in);
        fas_pkg::t_result r;
        logic [31:0] b, big, sml;
        logic [7:0] eb, es;
        logic [31:0] mb, ms, dif, acc;
        logic brw;
        int ex;
        b = b_in;
        r.status = fas_pkg::ST_NORMAL;
        brw = 1'b0;
        if (sub_op) b[31] = ~b[31];
        if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
            r.word = (a[30:23] != 8'd0) ? a : ((b[30:23] != 8'd0) ? b : 32'd0);
            return r;
        end
        if (a[30:0] >= b[30:0]) begin
            big = a; sml = b;
        end else begin
            big = b; sml = a;
        end
        eb = big[30:23];
        es = sml[30:23];
        mb = {8'd0, 1'b1, big[22:0]};
        ms = {8'd0, 1'b1, sml[22:0]};
        dif = 32'(eb) - 32'(es);
        if (dif >= 32'd1 && dif <= 32'd24) brw = ms[dif - 32'd1];
        ms = (dif <= 32'd24) ? (ms >> dif) : 32'd0;
        if (big[31] == sml[31]) begin
            acc = mb + ms;
        end else begin
            acc = mb - ms - 32'(brw);
        end
        ex = int'(eb);
        if (acc == 32'd0) begin
            r.word = 32'd0;
            return r;
        end
        if (acc[24]) begin
            acc = acc >> 1;
            ex++;
        end else begin
            while (!acc[23]) begin
                acc = acc << 1;
                ex--;
            end
        end
        if (ex >= 255) begin
            r.word = {big[31], 8'hFF, 23'd0};
            r.status = fas_pkg::ST_OVERFLOW;
        end else if (ex <= 0) begin
            r.word = {big[31], 31'd0};
            r.status = fas_pkg::ST_UNDERFLOW;
        end else begin
            r.word = {big[31], ex[7:0], acc[22:0]};
        end
        return r;
    endfunction

    assign o_pending = sums_due.size();

    always @(posedge i_clk) begin
        fas_pkg::t_result want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                sums_due.push_back(fadd_trunc(s_axis_tuser, s_axis_tdata[31:0],
                                              s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (sums_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sums_due.pop_front();
                    if (m_axis_tdata[31:0] !== want.word
                        || m_axis_tdata[33:32] !== want.status) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp word %h status %0d, got word %h status %0d",
                                     want.word, want.status, m_axis_tdata[31:0],
                                     m_axis_tdata[33:32]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: sim/float32_add_sub_truncating_top_tb.sv
`timescale 1ns / 1ps
module float32_add_sub_truncating_top_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // operand_a, operand_b
    logic        s_axis_tuser = 1'b0;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // result_word, status
    int          fail_count, pending, cycles = 0;
    logic        hold_off = 1'b0;
    logic [64:0] ops[$];

    always #6 i_clk = ~i_clk;

    float32_add_sub_truncating_top i_dut (.*);

    float32_add_sub_truncating_checker i_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] w;
        int p;
        w = $urandom;
        p = $urandom_range(0, 9);
        if (p < 5) w[30:23] = 8'(120 + $urandom_range(0, 16));
        else if (p == 5) w[30:23] = 8'($urandom_range(0, 3));
        else if (p == 6) w[30:23] = 8'($urandom_range(252, 255));
        return w;
    endfunction

    function automatic logic [31:0] near(input logic [31:0] x);
        logic [31:0] w;
        w = x;
        w[30:23] = 8'(32'(x[30:23]) + $urandom_range(0, 30) - 32'd3);
        w[22:0] = ($urandom_range(0, 1) != 0)
                  ? (x[22:0] ^ (23'h1 << $urandom_range(0, 22)))
                  : 23'($urandom);
        w[31] = 1'($urandom);
        return w;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int g;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end else begin
                g = gap_len();
                m_axis_tready <= (g == 0);
                repeat (g == 0 ? $urandom_range(1, 6) : g) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] a, b;
        int g;
        ops.push_back({1'b0, 32'h3F800000, 32'h3F800000});
        ops.push_back({1'b1, 32'h3F800000, 32'h3F800000});
        ops.push_back({1'b0, 32'h00000000, 32'h80000000});
        ops.push_back({1'b1, 32'h00000000, 32'h40000000});
        ops.push_back({1'b0, 32'hC0400000, 32'h00000000});
        ops.push_back({1'b0, 32'h007FFFFF, 32'h00400000});
        ops.push_back({1'b0, 32'h7F7FFFFF, 32'h7F7FFFFF});
        ops.push_back({1'b1, 32'h7F7FFFFF, 32'hFF000000});
        ops.push_back({1'b1, 32'h00800001, 32'h00800000});
        ops.push_back({1'b0, 32'h00FFFFFF, 32'h80800001});
        ops.push_back({1'b0, 32'h3F800000, 32'h33FFFFFF});
        ops.push_back({1'b1, 32'h3F800000, 32'h33FFFFFF});
        ops.push_back({1'b1, 32'h3F800000, 32'h33800000});
        ops.push_back({1'b1, 32'h3F800000, 32'h33000001});
        ops.push_back({1'b1, 32'h3F800000, 32'h3F7FFFFF});
        ops.push_back({1'b0, 32'h7F800000, 32'h00000000});
        ops.push_back({1'b1, 32'h00000000, 32'h7FC00001});
        ops.push_back({1'b0, 32'h7F800000, 32'h3F800000});
        ops.push_back({1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF});
        ops.push_back({1'b1, 32'h40000000, 32'hC0000000});
        ops.push_back({1'b0, 32'hBF800000, 32'h3FC00000});
        repeat (1100) begin
            a = rand_float();
            b = ($urandom_range(0, 2) == 0) ? rand_float() : near(a);
            ops.push_back({1'(($urandom_range(0, 1))), a, b});
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b1;
                repeat (150) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        while (ops.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            {s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]} <= ops.pop_front();
            do @(posedge i_clk); while (!s_axis_tready);
            g = (cycles > 250 && cycles < 450) ? 0 : gap_len();
            if (g > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
